@@ rtl/pbrs_pkg.sv @@
package pbrs_pkg;

  localparam int PS_W    = 17;
  localparam int OFF_W   = 16;
  localparam int LEN_W   = 13;
  localparam int PAGE_W  = 26;
  localparam int START_W = 32;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 2;

  localparam int ADDR_WIDTH_DEFAULT = 32;
  localparam int Q_DEPTH            = 2;

  localparam logic [PS_W-1:0]  PS_MIN   = 17'd128;
  localparam logic [PS_W-1:0]  PS_MAX   = 17'd65536;
  localparam logic [PS_W-1:0]  PS_RESET = 17'd256;
  localparam logic [LEN_W-1:0] LEN_MAX  = 13'd4096;

  localparam logic [PADDR_W-1:0] REG_PAGE_SIZE = 2'd0;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [OFF_W-1:0]  off;
    logic [LEN_W-1:0]  len;
    logic [PS_W-1:0]   ps;
  } pbrs_item_t;

endpackage

@@ rtl/pbrs_front.sv @@
module pbrs_front import pbrs_pkg::*; #(
  parameter int ADDR_WIDTH = ADDR_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [START_W-1:0] start_address,
  input  logic [LEN_W-1:0]   range_length,
  input  logic [PS_W-1:0]    page_bytes,
  output logic               item_valid,
  input  logic               item_ready,
  output pbrs_item_t         item
);

  localparam int CNT_W = $clog2(ADDR_WIDTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]            state;
  logic [CNT_W-1:0]      cnt;
  logic [ADDR_WIDTH-1:0] quo;
  logic [OFF_W-1:0]      rem;
  logic [PS_W-1:0]       ps;
  logic [LEN_W-1:0]      len;

  logic [PS_W-1:0]  ps_eff;
  logic [LEN_W-1:0] len_eff;
  logic [PS_W-1:0]  sh;
  logic             ge;
  logic [PS_W-1:0]  diff;

  always_comb begin
    if (page_bytes < PS_MIN) begin
      ps_eff = PS_MIN;
    end else if (page_bytes > PS_MAX) begin
      ps_eff = PS_MAX;
    end else begin
      ps_eff = page_bytes;
    end
    len_eff = (range_length > LEN_MAX) ? LEN_MAX : range_length;
    sh      = {rem, quo[ADDR_WIDTH-1]};
    ge      = (sh >= ps);
    diff    = sh - ps;
  end

  assign full       = (state != ST_IDLE);
  assign item_valid = (state == ST_OUT);
  assign item.page  = PAGE_W'(quo);
  assign item.off   = rem;
  assign item.len   = len;
  assign item.ps    = ps;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (push) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt == '0) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (item_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && push) begin
      quo <= start_address[ADDR_WIDTH-1:0];
      rem <= '0;
      ps  <= ps_eff;
      len <= len_eff;
      cnt <= CNT_W'(ADDR_WIDTH - 1);
    end else if (state == ST_DIV) begin
      rem <= ge ? diff[OFF_W-1:0] : sh[OFF_W-1:0];
      quo <= {quo[ADDR_WIDTH-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

@@ rtl/pbrs_queue.sv @@
module pbrs_queue import pbrs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  pbrs_item_t in_item,
  output logic       out_valid,
  input  logic       out_pop,
  output pbrs_item_t out_item
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  pbrs_item_t       mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr_en;
  logic             rd_en;

  assign in_ready  = (count != CNT_W'(Q_DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign wr_en     = in_valid && in_ready;
  assign rd_en     = out_pop && out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= in_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(Q_DEPTH))
    else $error("queue count exceeds its depth");

endmodule

@@ rtl/pbrs_back.sv @@
module pbrs_back import pbrs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  pbrs_item_t        q_item,
  output logic              empty,
  input  logic              pop,
  output logic [PAGE_W-1:0] chunk_page,
  output logic [OFF_W-1:0]  page_offset,
  output logic [LEN_W-1:0]  chunk_length,
  output logic              last_chunk
);

  logic              active;
  logic              first;
  logic [PAGE_W-1:0] page;
  logic [OFF_W-1:0]  off;
  logic [LEN_W-1:0]  left;
  logic [PS_W-1:0]   ps;
  logic              ovalid;

  logic [PS_W-1:0]  room;
  logic [LEN_W-1:0] take;
  logic [LEN_W-1:0] left_next;
  logic             fire;

  always_comb begin
    room      = first ? (ps - {1'b0, off}) : ps;
    take      = ({{(PS_W-LEN_W){1'b0}}, left} > room) ? room[LEN_W-1:0] : left;
    left_next = left - take;
  end

  assign fire  = active && (!ovalid || pop);
  assign q_pop = !active && q_valid;
  assign empty = !ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (q_pop) begin
        active <= 1'b1;
      end else if (fire && left_next == '0) begin
        active <= 1'b0;
      end
      if (fire) begin
        ovalid <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      page  <= q_item.page;
      off   <= q_item.off;
      left  <= q_item.len;
      ps    <= q_item.ps;
      first <= 1'b1;
    end else if (fire) begin
      page  <= page + 1'b1;
      off   <= '0;
      left  <= left_next;
      first <= 1'b0;
    end
    if (fire) begin
      chunk_page   <= page;
      page_offset  <= off;
      chunk_length <= take;
      last_chunk   <= (left_next == '0);
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> chunk_length <= LEN_MAX)
    else $error("chunk length above the range limit");

  a_inner_nonzero: assert property (@(posedge clk) disable iff (rst)
    ovalid && !last_chunk |-> chunk_length != '0)
    else $error("empty chunk that is not the last one");

  a_continue: assert property (@(posedge clk) disable iff (rst)
    fire && left_next != '0 |=> active)
    else $error("range dropped before its last chunk");

endmodule

@@ rtl/page_boundary_range_splitter.sv @@
// Splits a byte range into chunks that never cross a page boundary.
// Requests enter through a queue-like port: a request (start_address,
// range_length) is taken at a clock edge where push is high and full is low.
// Chunks leave through a queue-like port: while empty is low the oldest chunk
// is on chunk_page, page_offset, chunk_length and last_chunk, and it is taken
// at an edge where pop is high. The final chunk of each request has
// last_chunk set; a zero-length request yields a single zero-length chunk.
// The page size register sits at address 0 of the APB port and is clamped to
// 128..65536 when a request is taken; it resets to 256.
// The front end runs a restoring divider that retires one quotient bit per
// cycle; full stays high from the request until the queue takes its result,
// so no new request is taken before then. A two-entry queue then hands the
// request to the back end, which emits one chunk per cycle while the output
// is empty or popped, and loads the next request from the queue only after
// the last chunk of the current one has been emitted.
// When pop stays low the output register holds its chunk, the back end
// waits, the queue fills and full rises. Reset empties everything.
module page_boundary_range_splitter import pbrs_pkg::*; #(
  parameter int ADDR_WIDTH = ADDR_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic [START_W-1:0] start_address,
  input  logic [LEN_W-1:0]   range_length,
  output logic               empty,
  input  logic               pop,
  output logic [PAGE_W-1:0]  chunk_page,
  output logic [OFF_W-1:0]   page_offset,
  output logic [LEN_W-1:0]   chunk_length,
  output logic               last_chunk
);

  logic [PS_W-1:0] page_bytes;
  logic            f_valid;
  logic            f_ready;
  pbrs_item_t      f_item;
  logic            q_valid;
  logic            q_pop;
  pbrs_item_t      q_item;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_PAGE_SIZE) ? DATA_W'(page_bytes) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_bytes <= PS_RESET;
    end else if (psel && penable && pwrite && paddr == REG_PAGE_SIZE) begin
      page_bytes <= pwdata[PS_W-1:0];
    end
  end

  pbrs_front #(
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .start_address(start_address),
    .range_length (range_length),
    .page_bytes   (page_bytes),
    .item_valid   (f_valid),
    .item_ready   (f_ready),
    .item         (f_item)
  );

  pbrs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_item  (f_item),
    .out_valid(q_valid),
    .out_pop  (q_pop),
    .out_item (q_item)
  );

  pbrs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_item      (q_item),
    .empty       (empty),
    .pop         (pop),
    .chunk_page  (chunk_page),
    .page_offset (page_offset),
    .chunk_length(chunk_length),
    .last_chunk  (last_chunk)
  );

endmodule

@@ bench/page_boundary_range_splitter_tb.sv @@
`timescale 1ns / 100ps

module page_boundary_range_splitter_tb;
  import pbrs_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  chunk_len;
    logic              is_last;
  } chunk_t;

  class chunk_scoreboard;
    logic [PS_W-1:0] page_bytes_reg;
    chunk_t expected_chunks[$];
    int mismatches;

    function new();
      page_bytes_reg = PS_RESET;
      mismatches = 0;
    endfunction

    function void write_page_bytes(logic [DATA_W-1:0] value);
      page_bytes_reg = value[PS_W-1:0];
    endfunction

    function int unsigned effective_page_bytes();
      if (page_bytes_reg < PS_MIN) return PS_MIN;
      if (page_bytes_reg > PS_MAX) return PS_MAX;
      return page_bytes_reg;
    endfunction

    // Splits one accepted request into the chunks it must produce.
    function void note_request(logic [START_W-1:0] start, logic [LEN_W-1:0] req_len);
      int unsigned ps;
      int unsigned page;
      int unsigned left;
      int unsigned take;
      int unsigned room;
      chunk_t c;
      ps = effective_page_bytes();
      left = (req_len > LEN_MAX) ? LEN_MAX : req_len;
      page = start / ps;
      room = ps - start % ps;
      take = (left > room) ? room : left;
      left = left - take;
      c.page = PAGE_W'(page);
      c.offset = OFF_W'(start % ps);
      c.chunk_len = LEN_W'(take);
      c.is_last = (left == 0);
      expected_chunks.push_back(c);
      while (left != 0) begin
        page = page + 1;
        take = (left > ps) ? ps : left;
        left = left - take;
        c.page = PAGE_W'(page);
        c.offset = '0;
        c.chunk_len = LEN_W'(take);
        c.is_last = (left == 0);
        expected_chunks.push_back(c);
      end
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
    endfunction

    function void check_chunk(chunk_t got);
      chunk_t want;
      if (expected_chunks.size() == 0) begin
        report($sformatf("unexpected chunk page %0d offset %0d length %0d last %0b",
                         got.page, got.offset, got.chunk_len, got.is_last));
        return;
      end
      want = expected_chunks.pop_front();
      if (got.page !== want.page)
        report($sformatf("chunk_page expected %0d got %0d", want.page, got.page));
      if (got.offset !== want.offset)
        report($sformatf("page_offset expected %0d got %0d", want.offset, got.offset));
      if (got.chunk_len !== want.chunk_len)
        report($sformatf("chunk_length expected %0d got %0d", want.chunk_len, got.chunk_len));
      if (got.is_last !== want.is_last)
        report($sformatf("last_chunk expected %0b got %0b", want.is_last, got.is_last));
    endfunction

    function int pending();
      return expected_chunks.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = REG_PAGE_SIZE;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  logic [START_W-1:0] start_address = '0;
  logic [LEN_W-1:0] range_length = '0;
  logic empty;
  logic pop = 1'b0;
  logic [PAGE_W-1:0] chunk_page;
  logic [OFF_W-1:0] page_offset;
  logic [LEN_W-1:0] chunk_length;
  logic last_chunk;

  chunk_scoreboard sb = new();
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_pending = 1'b0;
  int quiet_cycles = 0;

  page_boundary_range_splitter dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .push(push),
    .full(full),
    .start_address(start_address),
    .range_length(range_length),
    .empty(empty),
    .pop(pop),
    .chunk_page(chunk_page),
    .page_offset(page_offset),
    .chunk_length(chunk_length),
    .last_chunk(last_chunk)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (push && !full) sb.note_request(start_address, range_length);
      if (pop && !empty) sb.check_chunk({chunk_page, page_offset, chunk_length, last_chunk});
      if ((push && !full) || (pop && !empty) || (psel && penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // The receiver takes chunks with random pauses; a pending hold stalls it long
  // enough for the request side to back up.
  initial begin : receiver
    int unsigned gap;
    while (rst) @(posedge clk);
    forever begin
      gap = rx_idle ? $urandom_range(0, 15) : 0;
      if (hold_pending) begin
        hold_pending = 1'b0;
        gap = gap + HOLD_CYCLES;
      end
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  task automatic send_request(logic [START_W-1:0] addr, logic [LEN_W-1:0] req_len);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    start_address <= addr;
    range_length <= req_len;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_page_bytes(logic [DATA_W-1:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_PAGE_SIZE;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_page_bytes(value);
  endtask

  function automatic logic [START_W-1:0] pick_start(int unsigned ps);
    logic [START_W-1:0] a;
    a = $urandom;
    case ($urandom_range(0, 3))
      0: pick_start = a;
      1: pick_start = a - a % ps + ps - $urandom_range(1, 8);
      2: pick_start = $urandom_range(0, 4 * ps);
      default: pick_start = a | 32'hFFFF_0000;
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 7))
      0: pick_len = '0;
      1, 2: pick_len = LEN_W'($urandom_range(1, 600));
      3: pick_len = LEN_MAX;
      4: pick_len = LEN_W'($urandom_range(4097, 8191));
      default: pick_len = LEN_W'($urandom_range(0, 4096));
    endcase
  endfunction

  task automatic random_requests(int n, bit hold);
    tx_idle = hold ? 1'b0 : ($urandom_range(0, 3) != 0);
    rx_idle = ($urandom_range(0, 3) != 0);
    if (hold) hold_pending = 1'b1;
    repeat (n) send_request(pick_start(sb.effective_page_bytes()), pick_len());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_request(32'h0000_0000, 13'd0);
    send_request(32'hFFFF_FFFF, 13'd0);
    send_request(32'h0000_0000, 13'd4096);
    send_request(32'h0000_00FF, 13'd2);
    send_request(32'h0000_0100, 13'd256);
    send_request(32'h0000_0064, 13'd8191);
    send_request(32'hFFFF_FFFF, 13'd4096);
    send_request(32'h8000_0000, 13'd1);
    send_request(32'h1234_5678, 13'd4097);

    set_page_bytes(32'd128);
    send_request(32'h0000_0001, 13'd4096);
    send_request(32'h0000_007F, 13'd1);
    send_request(32'hFFFF_FFFF, 13'd8191);

    set_page_bytes(32'd65536);
    send_request(32'hFFFF_0001, 13'd4096);
    send_request(32'h0000_FFFF, 13'd2);
    send_request(32'h0000_0000, 13'd1);
    random_requests(18, 1'b0);

    set_page_bytes(32'd300);
    random_requests(18, 1'b0);
    set_page_bytes(32'd0);
    random_requests(12, 1'b0);
    set_page_bytes(32'd131071);
    random_requests(12, 1'b0);
    set_page_bytes(32'hFFFE_0100);
    random_requests(20, 1'b1);
    set_page_bytes(32'd1000);
    random_requests(18, 1'b0);
    set_page_bytes(32'd127);
    random_requests(10, 1'b0);
    set_page_bytes($urandom_range(128, 65536));
    random_requests(27, 1'b0);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pbrs_pkg.sv
rtl/pbrs_front.sv
rtl/pbrs_queue.sv
rtl/pbrs_back.sv
rtl/page_boundary_range_splitter.sv
bench/page_boundary_range_splitter_tb.sv
